>>> hw/rtl/int8_dot_product_requantizer_macros.svh
// assertion macros for the dot product requantizer checker
`ifndef INT8_DOT_PRODUCT_REQUANTIZER_MACROS_SVH
`define INT8_DOT_PRODUCT_REQUANTIZER_MACROS_SVH
`define IDPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define IDPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hw/rtl/idpr_pkg.sv
// shared types and constants for the dot product requantizer
package idpr_pkg;
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_ACT_SIGNED = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_WGT_SIGNED = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_OUT_SIGNED = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ACT_ZP     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OUT_ZP     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ACT_MODE   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_RELU6      = 3'd6;
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_RELU  = 2'd1;
	localparam logic [1:0] MODE_RELU6 = 2'd2;
	localparam int MagCap = 4096;
	localparam int MaxLanes = 8;

	typedef struct packed {
		logic act_signed;
		logic wgt_signed;
		logic out_signed;
		logic signed [8:0] act_zp;
		logic signed [8:0] out_zp;
		logic [1:0] act_mode;
		logic signed [8:0] relu6_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mac;
		logic fin;
		logic mul;
		logic mulh;
		logic rnd;
		logic outp;
	} cmd_t;
endpackage

>>> hw/rtl/idpr_ctrl.sv
// sequencing controller for the dot product requantizer
module idpr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output idpr_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAC  = 3'd1;
	localparam logic [2:0] S_FIN  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_MULH = 3'd4;
	localparam logic [2:0] S_RND  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;
	logic [2:0] state_q, state_d;
	logic last_q;
	logic ovalid_q;
	logic take;

	assign in_ready = (state_q == S_IDLE);
	assign take = in_valid && in_ready;
	assign out_valid = ovalid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = take;
				if (take) state_d = S_MAC;
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				state_d = last_q ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_MULH;
			end
			S_MULH: begin
				cmd.mulh = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				if (!ovalid_q || out_ready) state_d = S_OUT;
			end
			S_OUT: begin
				cmd.outp = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) last_q <= in_last;
			if (cmd.outp) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end
endmodule

>>> hw/rtl/idpr_datapath.sv
// arithmetic datapath: lane products, accumulation, scaling and clamps
module idpr_datapath #(
	parameter int LANES = 8,
	parameter int ACC_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  idpr_pkg::cfg_t cfg,
	input  idpr_pkg::cmd_t cmd,
	input  logic [63:0] act_bytes,
	input  logic [63:0] wgt_bytes,
	input  logic act_padded,
	input  logic signed [31:0] bias,
	input  logic signed [8:0] wgt_zero_point,
	input  logic [30:0] scale_mult,
	input  logic [5:0] scale_shift,
	output logic signed [8:0] out_value
);
	localparam int NL = (LANES < idpr_pkg::MaxLanes) ? LANES : idpr_pkg::MaxLanes;
	localparam int ProdW = ACC_WIDTH + 31;
	localparam int SumW = 22;
	localparam int HalfW = (ACC_WIDTH + 1) / 2;
	localparam int HiW = ACC_WIDTH - HalfW;

	logic [63:0] act_q, wgt_q;
	logic pad_q;
	logic signed [31:0] bias_q;
	logic signed [8:0] wzp_q;
	logic [30:0] mult_q;
	logic [5:0] shift_q;
	logic [ACC_WIDTH-1:0] acc_q, total_q;
	logic [HalfW+30:0] plo_q;
	logic [ProdW-1:0] prod_q;
	logic [12:0] r_q;
	logic neg_q;
	logic signed [8:0] res_q;

	logic signed [SumW-1:0] lane_sum;
	always_comb begin
		logic signed [9:0] a, w;
		logic signed [19:0] p;
		lane_sum = '0;
		for (int i = 0; i < NL; i++) begin
			a = cfg.act_signed ? {{2{act_q[8*i+7]}}, act_q[8*i +: 8]} : {2'b0, act_q[8*i +: 8]};
			w = cfg.wgt_signed ? {{2{wgt_q[8*i+7]}}, wgt_q[8*i +: 8]} : {2'b0, wgt_q[8*i +: 8]};
			a = a - {cfg.act_zp[8], cfg.act_zp};
			w = w - {wzp_q[8], wzp_q};
			p = a * w;
			lane_sum = lane_sum + {{(SumW-20){p[19]}}, p};
		end
	end

	logic [ACC_WIDTH-1:0] sum_total, mag;
	assign sum_total = acc_q + {{(ACC_WIDTH-32){bias_q[31]}}, bias_q};
	assign mag = total_q[ACC_WIDTH-1] ? (~total_q + 1'b1) : total_q;

	logic [HiW+30:0] phi;
	assign phi = (HiW+31)'(mag[ACC_WIDTH-1:HalfW]) * (HiW+31)'(mult_q);

	logic [ProdW:0] rnd;
	logic [ProdW:0] shifted;
	logic [12:0] mag_r;
	always_comb begin
		rnd = {1'b0, prod_q};
		if (shift_q != 6'd0) rnd = rnd + ({{ProdW{1'b0}}, 1'b1} << (shift_q - 6'd1));
		shifted = rnd >> shift_q;
		if (shifted > (ProdW+1)'(idpr_pkg::MagCap)) mag_r = 13'(idpr_pkg::MagCap);
		else mag_r = shifted[12:0];
	end

	logic signed [13:0] q0, q1, lo, hi, zpo, r6;
	always_comb begin
		q0 = {1'b0, r_q};
		if (neg_q) q0 = -q0;
		lo = cfg.out_signed ? -14'sd128 : 14'sd0;
		hi = cfg.out_signed ? 14'sd127 : 14'sd255;
		zpo = {{5{cfg.out_zp[8]}}, cfg.out_zp};
		r6 = {{5{cfg.relu6_limit[8]}}, cfg.relu6_limit};
		q1 = q0 + zpo;
		if (q1 < lo) q1 = lo;
		if (q1 > hi) q1 = hi;
		if (cfg.act_mode != idpr_pkg::MODE_NONE) begin
			if (q1 < zpo) q1 = zpo;
			if (cfg.act_mode != idpr_pkg::MODE_RELU && q1 > r6) q1 = r6;
			if (q1 < lo) q1 = lo;
			if (q1 > hi) q1 = hi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= act_bytes;
			wgt_q <= wgt_bytes;
			pad_q <= act_padded;
			bias_q <= bias;
			wzp_q <= wgt_zero_point;
			mult_q <= scale_mult;
			shift_q <= scale_shift;
		end
		if (cmd.fin) begin
			total_q <= sum_total;
			neg_q <= sum_total[ACC_WIDTH-1];
		end
		if (cmd.mul) plo_q <= (HalfW+31)'(mag[HalfW-1:0]) * (HalfW+31)'(mult_q);
		if (cmd.mulh) prod_q <= ProdW'(plo_q) + (ProdW'(phi) << HalfW);
		if (cmd.rnd) r_q <= mag_r;
		if (cmd.outp) res_q <= q1[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= '0;
		else if (cmd.mac && !pad_q) acc_q <= acc_q + ACC_WIDTH'(lane_sum);
		else if (cmd.fin) acc_q <= '0;
	end

	assign out_value = res_q;
endmodule

>>> hw/rtl/int8_dot_product_requantizer.sv
// top level of the int8 dot product requantizer
//  channel | direction | payload
//  s_axis  | in        | chunk bytes, zero points, bias, scale
//  m_axis  | out       | out_value
//  cfg     | in        | register index and data
// a chunk is captured, then its lane products are multiply-accumulated
// a last chunk then goes on through bias add, two partial multiplies, round, clamp
// the scale multiply is split into two half-width partial products
// reset clears the accumulator and sets the config registers to defaults
// a held result stalls the next last chunk in its rounding state
module int8_dot_product_requantizer #(
	parameter int LANES = 8,
	parameter int ACC_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// act_bytes[63:0] wgt_bytes[127:64] act_padded[128] bias[160:129]
	// wgt_zero_point[169:161] scale_mult[200:170] scale_shift[206:201]
	input  logic [207:0] s_axis_tdata,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_value[8:0]
	output logic [15:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);
	idpr_pkg::cfg_t cfg_q;
	idpr_pkg::cmd_t cmd;
	logic signed [8:0] out_value;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.act_signed <= 1'b1;
			cfg_q.wgt_signed <= 1'b1;
			cfg_q.out_signed <= 1'b1;
			cfg_q.act_zp <= '0;
			cfg_q.out_zp <= '0;
			cfg_q.act_mode <= idpr_pkg::MODE_NONE;
			cfg_q.relu6_limit <= 9'sd127;
		end else if (cfg_valid) begin
			case (cfg_index)
				idpr_pkg::REG_ACT_SIGNED: cfg_q.act_signed <= cfg_data[0];
				idpr_pkg::REG_WGT_SIGNED: cfg_q.wgt_signed <= cfg_data[0];
				idpr_pkg::REG_OUT_SIGNED: cfg_q.out_signed <= cfg_data[0];
				idpr_pkg::REG_ACT_ZP: cfg_q.act_zp <= cfg_data;
				idpr_pkg::REG_OUT_ZP: cfg_q.out_zp <= cfg_data;
				idpr_pkg::REG_ACT_MODE: cfg_q.act_mode <= cfg_data[1:0];
				idpr_pkg::REG_RELU6: cfg_q.relu6_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	idpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .out_ready(m_axis_tready),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .cmd(cmd)
	);

	idpr_datapath #(.LANES(LANES), .ACC_WIDTH(ACC_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd),
		.act_bytes(s_axis_tdata[63:0]), .wgt_bytes(s_axis_tdata[127:64]),
		.act_padded(s_axis_tdata[128]), .bias(s_axis_tdata[160:129]),
		.wgt_zero_point(s_axis_tdata[169:161]), .scale_mult(s_axis_tdata[200:170]),
		.scale_shift(s_axis_tdata[206:201]), .out_value(out_value)
	);

	assign m_axis_tdata = {7'd0, out_value};
endmodule

>>> hw/rtl/idpr_checker.sv
// port-level checker for the dot product requantizer
`include "int8_dot_product_requantizer_macros.svh"
module idpr_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	`IDPR_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0, "tdata pad bits set")
	`IDPR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
	`IDPR_ASSERT_NEXT(a_busy_after, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
	`IDPR_ASSERT_NEXT(a_nonlast_quiet, clk, arst_n, s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid, !m_axis_tvalid, "result without last chunk")
endmodule

bind int8_dot_product_requantizer idpr_checker u_idpr_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
